[hw/rtl/pspr_pkg.sv]
// ----------------------------------------------------------------------------
// pspr_pkg
// Types and constants shared by the stage page region blocks.
// ----------------------------------------------------------------------------
package pspr_pkg;

  localparam int unsigned MAX_PARTITIONS = 16;
  localparam int unsigned MAX_STAGES     = 64;
  localparam int unsigned PART_W         = 4;
  localparam int unsigned STAGE_W        = 6;
  localparam int unsigned CNT_W          = 7;
  localparam int unsigned NUM_W          = 5;
  localparam int unsigned ADDR_W         = PART_W + STAGE_W;
  localparam int unsigned MEM_DEPTH      = MAX_PARTITIONS * MAX_STAGES;
  localparam int unsigned PAGE_W         = 32;
  localparam int unsigned DIV_STEPS      = PAGE_W;

  localparam logic [PAGE_W-1:0] WORKER_PAGE_COUNT = 32'd65536;
  localparam logic [PAGE_W-1:0] DRIVER_PAGE_COUNT = 32'd4096;

  typedef enum logic {
    OP_END_TASK = 1'b0,
    OP_QUERY    = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_PART  = 3'd1,
    ST_BAD_STAGE = 3'd2,
    ST_FULL      = 3'd3,
    ST_IGNORED   = 3'd4
  } status_t;

  typedef struct packed {
    logic               opcode;
    logic [PART_W-1:0]  part_idx;
    logic [STAGE_W-1:0] stage_idx;
    logic [PAGE_W-1:0]  last_page;
  } in_item_t;

  typedef struct packed {
    logic [PAGE_W-1:0] start_page;
    logic [PAGE_W-1:0] end_page;
    status_t           status;
  } out_item_t;

  // commands from the controller to the datapath and divider
  typedef struct packed {
    logic load;
    logic exec;
    logic cfg_load;
    logic div_start;
  } ctrl_cmd_t;

endpackage

[hw/rtl/pspr_div.sv]
// ----------------------------------------------------------------------------
// pspr_div
// Restoring divider, one quotient bit per cycle: worker pages / partitions.
// ----------------------------------------------------------------------------
module pspr_div import pspr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  divisor,
  output logic              done,
  output logic [PAGE_W-1:0] quotient
);

  localparam int unsigned STEP_W = $clog2(DIV_STEPS);

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [NUM_W-1:0]  rem_r, rem_nxt;
  logic [NUM_W-1:0]  dvs_r;
  logic [PAGE_W-1:0] quo_r, quo_nxt;
  logic [NUM_W:0]    trial;
  logic [NUM_W:0]    diff;
  logic              ge;
  logic              last_step;

  // dividend shifts out of the top of quo_r as quotient bits enter below
  assign trial     = {rem_r, quo_r[PAGE_W-1]};
  assign ge        = trial >= {1'b0, dvs_r};
  assign diff      = trial - {1'b0, dvs_r};
  assign last_step = step_r == STEP_W'(DIV_STEPS - 1);

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      run_nxt  = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = WORKER_PAGE_COUNT;
    end else if (run_r) begin
      rem_nxt  = ge ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
      quo_nxt  = {quo_r[PAGE_W-2:0], ge};
      step_nxt = step_r + STEP_W'(1);
      if (last_step) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[hw/rtl/pspr_ctrl.sv]
// ----------------------------------------------------------------------------
// pspr_ctrl
// Controller: sequences item accept, execute and share recompute.
// ----------------------------------------------------------------------------
module pspr_ctrl import pspr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      cfg_we,
  input  logic      div_done,
  output logic      busy,
  output ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DIV  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_w;

  assign busy_w = (state_r != S_IDLE) || cfg_we;

  always_comb begin
    state_nxt     = state_r;
    cmd.load      = 1'b0;
    cmd.exec      = 1'b0;
    cmd.cfg_load  = cfg_we;
    cmd.div_start = cfg_we;
    unique case (state_r)
      S_IDLE: begin
        if (cfg_we) begin
          state_nxt = S_DIV;
        end else if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = cfg_we ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        if (!cfg_we && div_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = busy_w;

endmodule

[hw/rtl/pspr_dp.sv]
// ----------------------------------------------------------------------------
// pspr_dp
// Datapath: boundary memory, per-partition counts, region arithmetic.
// ----------------------------------------------------------------------------
module pspr_dp import pspr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ctrl_cmd_t         cmd,
  input  logic              div_done,
  input  logic [PAGE_W-1:0] div_quo,
  output logic [NUM_W-1:0]  div_divisor,
  input  in_item_t          in_data,
  input  logic [NUM_W-1:0]  cfg_wdata,
  output logic              out_valid,
  output out_item_t         out_data
);

  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [PAGE_W-1:0] share_r;
  logic [CNT_W-1:0]  cnt_r [MAX_PARTITIONS];
  logic [PAGE_W-1:0] mem [MEM_DEPTH];
  logic [PAGE_W-1:0] rd0_r, rd1_r;
  logic [PAGE_W-1:0] prod_r;
  in_item_t          item_r;
  logic              out_valid_r;
  out_item_t         out_data_r, out_data_nxt;

  logic [ADDR_W-1:0]          rd0_addr, rd1_addr, wr_addr;
  logic [STAGE_W-1:0]         st_next;
  logic [PAGE_W-1:0]          prod_full;
  logic [CNT_W-1:0]           cur_cnt, last_idx, st_ext;
  logic [PAGE_W-1:0]          pstart, pend, wr_data;
  logic                       bad_part, do_write;

  // register clamp: zero acts as one, saturate at the partition limit
  always_comb begin
    if (cfg_wdata == '0) begin
      num_nxt = NUM_W'(1);
    end else if (cfg_wdata > NUM_W'(MAX_PARTITIONS)) begin
      num_nxt = NUM_W'(MAX_PARTITIONS);
    end else begin
      num_nxt = cfg_wdata;
    end
  end
  assign div_divisor = num_nxt;

  // read side, captured at the accept beat
  assign st_next   = in_data.stage_idx + STAGE_W'(1);
  assign rd0_addr  = {in_data.part_idx, in_data.stage_idx};
  assign rd1_addr  = {in_data.part_idx, st_next};
  assign prod_full = PAGE_W'(in_data.part_idx) * share_r;

  // execute side
  assign cur_cnt  = cnt_r[item_r.part_idx];
  assign last_idx = cur_cnt - CNT_W'(1);
  assign st_ext   = {1'b0, item_r.stage_idx};
  assign bad_part = {1'b0, item_r.part_idx} >= num_r;
  assign pstart   = DRIVER_PAGE_COUNT + prod_r;
  assign pend     = pstart + share_r;
  assign wr_addr  = {item_r.part_idx, cur_cnt[STAGE_W-1:0]};
  assign wr_data  = item_r.last_page + PAGE_W'(1);

  always_comb begin
    out_data_nxt.start_page = '0;
    out_data_nxt.end_page   = '0;
    out_data_nxt.status     = ST_OK;
    do_write                = 1'b0;
    if (bad_part) begin
      out_data_nxt.status = ST_BAD_PART;
    end else if (item_r.opcode == OP_END_TASK) begin
      priority if (st_ext < last_idx) begin
        out_data_nxt.status = ST_IGNORED;
      end else if (cur_cnt >= CNT_W'(MAX_STAGES)) begin
        out_data_nxt.status = ST_FULL;
      end else begin
        do_write = cmd.exec;
      end
    end else begin
      if (st_ext >= cur_cnt) begin
        out_data_nxt.status = ST_BAD_STAGE;
      end else begin
        // entry zero of a list is the partition start itself
        out_data_nxt.start_page = (item_r.stage_idx == '0) ? pstart : rd0_r;
        out_data_nxt.end_page   = (st_ext == last_idx) ? pend : rd1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.load) begin
      rd0_r <= mem[rd0_addr];
      rd1_r <= mem[rd1_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
      prod_r <= prod_full;
    end
    if (cmd.exec) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.cfg_load) begin
      for (int i = 0; i < MAX_PARTITIONS; i++) begin
        cnt_r[i] <= CNT_W'(1);
      end
    end else if (do_write) begin
      cnt_r[item_r.part_idx] <= cur_cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r       <= NUM_W'(1);
      share_r     <= WORKER_PAGE_COUNT;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.exec;
      if (cmd.cfg_load) begin
        num_r <= num_nxt;
      end
      if (div_done) begin
        share_r <= div_quo;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hw/rtl/partition_stage_page_regions.sv]
// ----------------------------------------------------------------------------
// partition_stage_page_regions
// Per-partition stage page boundary lists with region queries.
// ----------------------------------------------------------------------------
// Usage: an item on in_data is taken at a clock edge with start high and busy
// low. Opcode end-task appends last_page+1 to the partition's boundary list;
// opcode query returns the stage's start and end page. Each item gives one
// beat on out_data, marked by out_valid for exactly one cycle.
// Timing: the accept edge reads the boundary memory at two addresses and the
// item, the next edge reads the partition count, executes and writes back, so
// busy is high for one cycle and no new item is taken while one executes. The
// result beat appears in the cycle where the next item may already enter.
// The single read-then-write pass over the boundary memory paces the items.
// A cfg_we write of num_partitions restarts every list and recomputes the
// partition share in a bit-serial divider: busy stays high until it is done.
// Reset: rst_n low sets one partition, the full worker share and one entry
// per list, with no clearing pass. The receiver cannot stall: out_valid beats
// must be taken when they appear.
// ----------------------------------------------------------------------------
module partition_stage_page_regions import pspr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_data,
  output logic             out_valid,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [NUM_W-1:0] cfg_wdata
);

  ctrl_cmd_t         cmd;
  logic              div_done;
  logic [PAGE_W-1:0] div_quo;
  logic [NUM_W-1:0]  div_divisor;

  pspr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .cfg_we   (cfg_we),
    .div_done (div_done),
    .busy     (busy),
    .cmd      (cmd)
  );

  pspr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  pspr_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .div_done    (div_done),
    .div_quo     (div_quo),
    .div_divisor (div_divisor),
    .in_data     (in_data),
    .cfg_wdata   (cfg_wdata),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> cmd.exec)
    else $error("accepted item not executed");

  a_exec_beat: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid)
    else $error("executed item gave no result beat");

  a_beat_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cmd.exec))
    else $error("result beat without an executed item");

  a_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !div_done)
    else $error("share updated while an item executes");

endmodule
